[rtl/core/i2p_pkg.sv]
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, constants and helpers for the infix-to-postfix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2p_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_PAREN = 2'd2;

  typedef struct packed {
    logic [7:0] symbol;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    CLS_END,
    CLS_ALNUM,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OP
  } sym_class_t;

  typedef enum logic [2:0] {
    SEL_SPACE,
    SEL_SYM,
    SEL_TOP,
    SEL_TERM,
    SEL_ERR_FULL,
    SEL_ERR_PAREN
  } res_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_POP_CH,
    S_FULL,
    S_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic     load;
    logic     emit;
    res_sel_t sel;
    logic     push;
    logic     pop;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    sym_class_t cls;
    logic       count_zero;
    logic       stack_full;
    logic       top_is_open;
    logic       top_pops;
    logic       pend_valid;
    logic       out_free;
  } dp_stat_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    if (c == CH_MUL || c == CH_DIV) p = 2'd2;
    return p;
  endfunction

endpackage

`default_nettype wire

[rtl/core/infix_to_postfix_converter_core.sv]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// Shunting-yard converter: infix characters in, postfix characters out.
// ----------------------------------------------------------------------------
// One symbol is taken at a time. An operator, ')' or end item may pop stack
// entries, and a push onto a full stack is dropped. Each entry popped for
// output gives two results (a space and the entry; a '(' matched by ')' is
// popped with no result), produced one per cycle by the sequencer while the
// output channel does not stall, through a single stack read port and a
// one-entry pending stage that marks the last result of each symbol.
// The stack holds STACK_DEPTH entries; an error result (status 1 or 2) ends
// the symbol's results, and the stack stays consistent after it. No clearing
// pass runs after reset: only the entry count is reset.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter_core
  import i2p_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  // infix symbol channel
  input  logic      sym_valid,
  output logic      sym_stall,
  input  in_item_t  sym,
  // postfix result channel
  output logic      post_valid,
  input  logic      post_stall,
  output out_item_t post
);

  dp_cmd_t     cmd;
  dp_stat_t    st;
  ctrl_state_t state;

  i2p_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .sym_valid (sym_valid),
    .sym_stall (sym_stall),
    .st        (st),
    .cmd       (cmd),
    .state     (state)
  );

  i2p_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .sym        (sym),
    .cmd        (cmd),
    .st         (st),
    .post_stall (post_stall),
    .post_valid (post_valid),
    .post       (post)
  );

  // Every symbol's last result has left the pending stage before the next
  // symbol is taken.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !st.pend_valid)
    else $error("pending result left over when idle");

  // Error results carry no character.
  a_err_no_char: assert property (@(posedge clk) disable iff (rst)
    (post_valid && post.status != ST_OK) |-> !post.has_char)
    else $error("error result carries a character");

  // A characterless ok result is the terminator and must close its symbol.
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    (post_valid && !post.has_char && post.status == ST_OK) |-> post.last)
    else $error("terminator without last");

  // Errors are always the final result of their symbol.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (post_valid && post.status != ST_OK) |-> post.last)
    else $error("error result not last");

endmodule

`default_nettype wire

[rtl/core/i2p_dpath.sv]
// ----------------------------------------------------------------------------
// i2p_dpath
// Operator stack, current symbol, pending result and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_dpath
  import i2p_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  sym,
  input  dp_cmd_t   cmd,
  output dp_stat_t  st,
  input  logic      post_stall,
  output logic      post_valid,
  output out_item_t post
);

  logic [7:0]       stack [STACK_DEPTH];
  logic [CNT_W-1:0] count;
  logic [7:0]       cur_sym;
  logic             cur_end;
  out_item_t        pend;
  logic             pend_valid;
  logic [IDX_W-1:0] under_idx;
  logic [7:0]       top;
  out_item_t        res;
  out_item_t        post_next;
  logic             post_load;

  // entry just below the top; it becomes the top after a pop
  assign under_idx = IDX_W'(count - CNT_W'(2));

  always_comb begin
    if (cur_end) begin
      st.cls = CLS_END;
    end else if (cur_sym inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
      st.cls = CLS_ALNUM;
    end else if (cur_sym == CH_OPEN) begin
      st.cls = CLS_OPEN;
    end else if (cur_sym == CH_CLOSE) begin
      st.cls = CLS_CLOSE;
    end else begin
      st.cls = CLS_OP;
    end
    st.count_zero  = (count == '0);
    st.stack_full  = (count == CNT_W'(STACK_DEPTH));
    st.top_is_open = (top == CH_OPEN);
    st.top_pops    = (prec_of(top) >= prec_of(cur_sym));
    st.pend_valid  = pend_valid;
    st.out_free    = !post_valid || !post_stall;
  end

  always_comb begin
    res = '0;
    case (cmd.sel)
      SEL_SPACE: begin
        res.out_char = CH_SPACE;
        res.has_char = 1'b1;
      end
      SEL_SYM: begin
        res.out_char = cur_sym;
        res.has_char = 1'b1;
      end
      SEL_TOP: begin
        res.out_char = top;
        res.has_char = 1'b1;
      end
      SEL_ERR_FULL:  res.status = ST_FULL;
      SEL_ERR_PAREN: res.status = ST_PAREN;
      default:       res = '0;
    endcase
  end

  // Top of stack is kept in a register, refreshed on every push and on every pop that leaves the stack non-empty.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_sym <= sym.symbol;
      cur_end <= sym.is_end;
    end
    if (cmd.push) begin
      stack[count[IDX_W-1:0]] <= cur_sym;
      top                     <= cur_sym;
    end else if (cmd.pop && count > CNT_W'(1)) begin
      top <= stack[under_idx];
    end
    if (rst) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + CNT_W'(1);
    end else if (cmd.pop) begin
      count <= count - CNT_W'(1);
    end
  end

  // Pending stage: a result is held until the next one shows whether it is last.
  assign post_load = pend_valid && (cmd.emit || cmd.finish);

  always_comb begin
    post_next = pend;
    if (cmd.finish) post_next.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      post_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        pend       <= res;
        pend_valid <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid <= 1'b0;
      end
      if (post_load) begin
        post       <= post_next;
        post_valid <= 1'b1;
      end else if (!post_stall) begin
        post_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/i2p_ctrl.sv]
// ----------------------------------------------------------------------------
// i2p_ctrl
// Sequencer that walks one input symbol through its stack operations.
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_ctrl
  import i2p_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        sym_valid,
  output logic        sym_stall,
  input  dp_stat_t    st,
  output dp_cmd_t     cmd,
  output ctrl_state_t state
);

  ctrl_state_t state_next;
  logic        step_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    step_ok    = !st.pend_valid || st.out_free;
    state_next = state;
    cmd        = '0;
    cmd.sel    = SEL_SPACE;
    sym_stall  = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (sym_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (step_ok) begin
          case (st.cls)
            CLS_END: begin
              cmd.emit = 1'b1;
              if (!st.count_zero) begin
                state_next = S_POP_CH;
              end else begin
                cmd.sel    = SEL_TERM;
                state_next = S_FLUSH;
              end
            end
            CLS_ALNUM: begin
              cmd.emit   = 1'b1;
              cmd.sel    = SEL_SYM;
              state_next = S_FLUSH;
            end
            CLS_OPEN: begin
              if (st.stack_full) begin
                cmd.emit = 1'b1;
                cmd.sel  = SEL_ERR_FULL;
              end else begin
                cmd.push = 1'b1;
              end
              state_next = S_FLUSH;
            end
            CLS_CLOSE: begin
              if (!st.count_zero && !st.top_is_open) begin
                cmd.emit   = 1'b1;
                state_next = S_POP_CH;
              end else if (!st.count_zero) begin
                cmd.pop    = 1'b1;
                state_next = S_FLUSH;
              end else begin
                cmd.emit   = 1'b1;
                cmd.sel    = SEL_ERR_PAREN;
                state_next = S_FLUSH;
              end
            end
            default: begin
              cmd.emit = 1'b1;
              if (!st.count_zero && !st.top_is_open && st.top_pops) begin
                state_next = S_POP_CH;
              end else if (st.stack_full) begin
                state_next = S_FULL;
              end else begin
                cmd.push   = 1'b1;
                state_next = S_FLUSH;
              end
            end
          endcase
        end
      end
      S_POP_CH: begin
        if (step_ok) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_TOP;
          cmd.pop    = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_FULL: begin
        if (step_ok) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_ERR_FULL;
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (step_ok) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire
